@@ rtl/dtp_pkg.sv @@
`default_nettype none

package dtp_pkg;

    // Image size defaults
    localparam int IMG_WIDTH_DEF  = 640;
    localparam int IMG_HEIGHT_DEF = 480;

    // Field widths
    localparam int IDX_W      = 19;
    localparam int COLOR_W    = 8;
    localparam int RGB_W      = 3 * COLOR_W;
    localparam int DEPTH_W    = 16;
    localparam int DIR_W      = 16;
    localparam int ORG_W      = 21;
    localparam int PT_W       = 24;
    localparam int COEF_W     = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;
    localparam int ORIGIN_W   = 3 * ORG_W;

    // Arithmetic widths
    localparam int FRAC_W = 14;
    localparam int PROD_W = DEPTH_W + 1 + DIR_W;
    localparam int SUM_W  = PROD_W + 4;
    localparam int TERM_W = COEF_W + PT_W;
    localparam int LIN_W  = TERM_W + 2;

    localparam int RND_POS = 8192;
    localparam int RND_NEG = 8191;
    localparam int PT_MAX  = 8388607;
    localparam int PT_MIN  = -8388608;

    localparam logic [COLOR_W-1:0] ALPHA_FULL = 8'd255;

    // Request kinds
    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_DEPTH = 1'b1;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MAP_EN  = 3'd0,
        CFG_ORIGIN  = 3'd1,
        CFG_X01     = 3'd2,
        CFG_X23     = 3'd3,
        CFG_Y01     = 3'd4,
        CFG_Y23     = 3'd5,
        CFG_W01     = 3'd6,
        CFG_W23     = 3'd7
    } cfg_idx_t;

    // Request kind and color load payload
    typedef struct packed {
        logic             depth_item;
        logic [IDX_W-1:0] widx;
        logic [RGB_W-1:0] wdata;
    } ld_t;

    // Side data that travels with an item after the point is known
    typedef struct packed {
        ld_t                   ld;
        logic signed [PT_W-1:0] px;
        logic signed [PT_W-1:0] py;
        logic signed [PT_W-1:0] pz;
        logic                  bad;
        logic                  neg_x;
        logic                  neg_y;
    } carry_t;

endpackage

`default_nettype wire

@@ rtl/dtp_ram.sv @@
`default_nettype none

module dtp_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 307200
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [0:DEPTH-1];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

@@ rtl/dtp_div.sv @@
`default_nettype none

module dtp_div #(
    parameter int MW = 58,
    parameter int QB = 10
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            en,
    input  logic            in_valid,
    input  logic [MW-1:0]   in_num_x,
    input  logic [MW-1:0]   in_num_y,
    input  logic [MW-1:0]   in_den,
    input  dtp_pkg::carry_t in_side,
    output logic            out_valid,
    output logic [QB-1:0]   out_qx,
    output logic [QB-1:0]   out_qy,
    output dtp_pkg::carry_t out_side
);
    import dtp_pkg::*;

    localparam int DW = MW + QB;

    logic [QB:0]   v_reg;
    logic [MW-1:0] rx_reg [0:QB];
    logic [MW-1:0] ry_reg [0:QB];
    logic [MW-1:0] d_reg  [0:QB];
    logic [QB-1:0] qx_reg [0:QB];
    logic [QB-1:0] qy_reg [0:QB];
    carry_t        side_reg [0:QB];

    logic [DW-1:0] lim;
    logic          ovf_x;
    logic          ovf_y;
    carry_t        side_in;

    logic [DW-1:0] dsh     [0:QB-1];
    logic [QB-1:0] gx;
    logic [QB-1:0] gy;
    logic [MW-1:0] rx_next [0:QB-1];
    logic [MW-1:0] ry_next [0:QB-1];
    logic [QB-1:0] qx_next [0:QB-1];
    logic [QB-1:0] qy_next [0:QB-1];

    // Flag quotients that do not fit in QB bits as out of range
    assign lim   = {in_den, {QB{1'b0}}};
    assign ovf_x = {{QB{1'b0}}, in_num_x} >= lim;
    assign ovf_y = {{QB{1'b0}}, in_num_y} >= lim;

    always_comb begin
        side_in     = in_side;
        side_in.bad = in_side.bad | ovf_x | ovf_y;
    end

    // One quotient bit per stage, most significant first
    always_comb begin
        for (int k = 0; k < QB; k++) begin
            dsh[k] = {{QB{1'b0}}, d_reg[k]} << (QB - 1 - k);
            gx[k]  = {{QB{1'b0}}, rx_reg[k]} >= dsh[k];
            gy[k]  = {{QB{1'b0}}, ry_reg[k]} >= dsh[k];
            rx_next[k] = gx[k] ? rx_reg[k] - dsh[k][MW-1:0] : rx_reg[k];
            ry_next[k] = gy[k] ? ry_reg[k] - dsh[k][MW-1:0] : ry_reg[k];
            qx_next[k] = qx_reg[k];
            qy_next[k] = qy_reg[k];
            qx_next[k][QB-1-k] = gx[k];
            qy_next[k][QB-1-k] = gy[k];
        end
    end

    // Advance every stage together
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (en) begin
            v_reg <= {v_reg[QB-1:0], in_valid};
        end
        if (en) begin
            rx_reg[0]   <= in_num_x;
            ry_reg[0]   <= in_num_y;
            d_reg[0]    <= in_den;
            qx_reg[0]   <= '0;
            qy_reg[0]   <= '0;
            side_reg[0] <= side_in;
            for (int k = 0; k < QB; k++) begin
                rx_reg[k+1]   <= rx_next[k];
                ry_reg[k+1]   <= ry_next[k];
                d_reg[k+1]    <= d_reg[k];
                qx_reg[k+1]   <= qx_next[k];
                qy_reg[k+1]   <= qy_next[k];
                side_reg[k+1] <= side_reg[k];
            end
        end
    end

    assign out_valid = v_reg[QB];
    assign out_qx    = qx_reg[QB];
    assign out_qy    = qy_reg[QB];
    assign out_side  = side_reg[QB];

endmodule

`default_nettype wire

@@ rtl/depth_to_point_rgbd_register.sv @@
`default_nettype none

// Channel   | Direction | Handshake           | Payload
// input     | in        | s_valid / s_ready   | s_req_type .. s_ray_dz
// result    | out       | m_valid / m_ready   | m_point_x .. m_out_a
// config    | in        | cfg_wr_en           | cfg_wr_index, cfg_wr_data
//
// One item enters per cycle; a held result freezes the whole pipe and drops
// s_ready. A depth item's result passes the numbered stages, a divider that
// gives one quotient bit per stage, QB = clog2(max(IMG_WIDTH, IMG_HEIGHT))
// bits, then stages A and B. Color loads write the store late in the pipe
// and give no result. Reset clears valid bits and config, not the store.
module depth_to_point_rgbd_register #(
    parameter int IMG_WIDTH  = dtp_pkg::IMG_WIDTH_DEF,
    parameter int IMG_HEIGHT = dtp_pkg::IMG_HEIGHT_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_wr_en,
    input  logic [dtp_pkg::CFG_IDX_W-1:0]    cfg_wr_index,
    input  logic [dtp_pkg::CFG_DATA_W-1:0]   cfg_wr_data,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic                             s_req_type,
    input  logic [dtp_pkg::IDX_W-1:0]        s_pixel_index,
    input  logic [dtp_pkg::COLOR_W-1:0]      s_color_r,
    input  logic [dtp_pkg::COLOR_W-1:0]      s_color_g,
    input  logic [dtp_pkg::COLOR_W-1:0]      s_color_b,
    input  logic [dtp_pkg::DEPTH_W-1:0]      s_depth_mm,
    input  logic signed [dtp_pkg::DIR_W-1:0] s_ray_dx,
    input  logic signed [dtp_pkg::DIR_W-1:0] s_ray_dy,
    input  logic signed [dtp_pkg::DIR_W-1:0] s_ray_dz,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic signed [dtp_pkg::PT_W-1:0]  m_point_x,
    output logic signed [dtp_pkg::PT_W-1:0]  m_point_y,
    output logic signed [dtp_pkg::PT_W-1:0]  m_point_z,
    output logic [dtp_pkg::COLOR_W-1:0]      m_out_r,
    output logic [dtp_pkg::COLOR_W-1:0]      m_out_g,
    output logic [dtp_pkg::COLOR_W-1:0]      m_out_b,
    output logic [dtp_pkg::COLOR_W-1:0]      m_out_a
);
    import dtp_pkg::*;

    localparam int STORE_DEPTH = IMG_WIDTH * IMG_HEIGHT;
    localparam int AW          = $clog2(STORE_DEPTH);
    localparam int QB = $clog2((IMG_WIDTH > IMG_HEIGHT) ? IMG_WIDTH : IMG_HEIGHT);

    // Round to nearest with ties away from zero, then saturate
    function automatic logic signed [PT_W-1:0] round_sat(input logic signed [SUM_W-1:0] s);
        logic signed [SUM_W-1:0] r;
        logic signed [PT_W-1:0]  res;
        r = (s + (s[SUM_W-1] ? SUM_W'(RND_NEG) : SUM_W'(RND_POS))) >>> FRAC_W;
        if (r > $signed(SUM_W'(PT_MAX))) begin
            res = PT_W'(PT_MAX);
        end else if (r < $signed(SUM_W'(PT_MIN))) begin
            res = PT_W'(PT_MIN);
        end else begin
            res = r[PT_W-1:0];
        end
        return res;
    endfunction

    // Configuration registers
    logic                  map_en_reg;
    logic [ORIGIN_W-1:0]   origin_reg;
    logic [CFG_DATA_W-1:0] coef_x01_reg, coef_x23_reg;
    logic [CFG_DATA_W-1:0] coef_y01_reg, coef_y23_reg;
    logic [CFG_DATA_W-1:0] coef_w01_reg, coef_w23_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            map_en_reg   <= 1'b0;
            origin_reg   <= '0;
            coef_x01_reg <= '0;
            coef_x23_reg <= '0;
            coef_y01_reg <= '0;
            coef_y23_reg <= '0;
            coef_w01_reg <= '0;
            coef_w23_reg <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_wr_index)
                CFG_MAP_EN: map_en_reg   <= cfg_wr_data[0];
                CFG_ORIGIN: origin_reg   <= cfg_wr_data[ORIGIN_W-1:0];
                CFG_X01:    coef_x01_reg <= cfg_wr_data;
                CFG_X23:    coef_x23_reg <= cfg_wr_data;
                CFG_Y01:    coef_y01_reg <= cfg_wr_data;
                CFG_Y23:    coef_y23_reg <= cfg_wr_data;
                CFG_W01:    coef_w01_reg <= cfg_wr_data;
                CFG_W23:    coef_w23_reg <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    logic signed [ORG_W-1:0]  org_x, org_y, org_z;
    logic signed [COEF_W-1:0] cx0, cx1, cx2, cx3;
    logic signed [COEF_W-1:0] cy0, cy1, cy2, cy3;
    logic signed [COEF_W-1:0] cw0, cw1, cw2, cw3;

    assign org_x = origin_reg[ORG_W-1:0];
    assign org_y = origin_reg[2*ORG_W-1:ORG_W];
    assign org_z = origin_reg[3*ORG_W-1:2*ORG_W];
    assign cx0 = coef_x01_reg[COEF_W-1:0];
    assign cx1 = coef_x01_reg[2*COEF_W-1:COEF_W];
    assign cx2 = coef_x23_reg[COEF_W-1:0];
    assign cx3 = coef_x23_reg[2*COEF_W-1:COEF_W];
    assign cy0 = coef_y01_reg[COEF_W-1:0];
    assign cy1 = coef_y01_reg[2*COEF_W-1:COEF_W];
    assign cy2 = coef_y23_reg[COEF_W-1:0];
    assign cy3 = coef_y23_reg[2*COEF_W-1:COEF_W];
    assign cw0 = coef_w01_reg[COEF_W-1:0];
    assign cw1 = coef_w01_reg[2*COEF_W-1:COEF_W];
    assign cw2 = coef_w23_reg[COEF_W-1:0];
    assign cw3 = coef_w23_reg[2*COEF_W-1:COEF_W];

    // Whole pipe advances unless a result is held
    logic adv;
    logic b_v_reg;
    carry_t b_side_reg;
    assign m_valid = b_v_reg & b_side_reg.ld.depth_item;
    assign adv     = !m_valid || m_ready;
    assign s_ready = adv;

    // Stage 1: register the transfer
    logic                     st1_v_reg;
    ld_t                      st1_ld_reg;
    logic [DEPTH_W-1:0]       st1_depth_reg;
    logic signed [DIR_W-1:0]  st1_dx_reg, st1_dy_reg, st1_dz_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st1_v_reg <= 1'b0;
        end else if (adv) begin
            st1_v_reg <= s_valid;
        end
        if (adv) begin
            st1_ld_reg    <= '{depth_item: s_req_type == REQ_DEPTH, widx: s_pixel_index,
                               wdata: {s_color_r, s_color_g, s_color_b}};
            st1_depth_reg <= s_depth_mm;
            st1_dx_reg    <= s_ray_dx;
            st1_dy_reg    <= s_ray_dy;
            st1_dz_reg    <= s_ray_dz;
        end
    end

    // Stage 2: depth times direction
    logic signed [PROD_W-1:0] prod_x_next, prod_y_next, prod_z_next;
    logic signed [DEPTH_W:0]  dep_s;
    assign dep_s       = $signed({1'b0, st1_depth_reg});
    assign prod_x_next = dep_s * st1_dx_reg;
    assign prod_y_next = dep_s * st1_dy_reg;
    assign prod_z_next = dep_s * st1_dz_reg;

    logic                     st2_v_reg;
    ld_t                      st2_ld_reg;
    logic signed [PROD_W-1:0] st2_px_reg, st2_py_reg, st2_pz_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st2_v_reg <= 1'b0;
        end else if (adv) begin
            st2_v_reg <= st1_v_reg;
        end
        if (adv) begin
            st2_ld_reg <= st1_ld_reg;
            st2_px_reg <= prod_x_next;
            st2_py_reg <= prod_y_next;
            st2_pz_reg <= prod_z_next;
        end
    end

    // Stage 3: add the scaled origin
    logic signed [SUM_W-1:0] sum_x_next, sum_y_next, sum_z_next;
    assign sum_x_next = $signed({{(SUM_W-ORG_W-FRAC_W){org_x[ORG_W-1]}}, org_x,
                                 {FRAC_W{1'b0}}}) + SUM_W'(st2_px_reg);
    assign sum_y_next = $signed({{(SUM_W-ORG_W-FRAC_W){org_y[ORG_W-1]}}, org_y,
                                 {FRAC_W{1'b0}}}) + SUM_W'(st2_py_reg);
    assign sum_z_next = $signed({{(SUM_W-ORG_W-FRAC_W){org_z[ORG_W-1]}}, org_z,
                                 {FRAC_W{1'b0}}}) + SUM_W'(st2_pz_reg);

    logic                    st3_v_reg;
    ld_t                     st3_ld_reg;
    logic signed [SUM_W-1:0] st3_sx_reg, st3_sy_reg, st3_sz_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st3_v_reg <= 1'b0;
        end else if (adv) begin
            st3_v_reg <= st2_v_reg;
        end
        if (adv) begin
            st3_ld_reg <= st2_ld_reg;
            st3_sx_reg <= sum_x_next;
            st3_sy_reg <= sum_y_next;
            st3_sz_reg <= sum_z_next;
        end
    end

    // Stage 4: round and saturate the point
    logic   st4_v_reg;
    carry_t st4_c_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st4_v_reg <= 1'b0;
        end else if (adv) begin
            st4_v_reg <= st3_v_reg;
        end
        if (adv) begin
            st4_c_reg <= '{ld: st3_ld_reg, px: round_sat(st3_sx_reg),
                           py: round_sat(st3_sy_reg), pz: round_sat(st3_sz_reg),
                           bad: 1'b0, neg_x: 1'b0, neg_y: 1'b0};
        end
    end

    // Stage 5: coefficient products
    logic signed [TERM_W-1:0] tx0, tx1, tx2, ty0, ty1, ty2, tw0, tw1, tw2;
    assign tx0 = cx0 * st4_c_reg.px;
    assign tx1 = cx1 * st4_c_reg.py;
    assign tx2 = cx2 * st4_c_reg.pz;
    assign ty0 = cy0 * st4_c_reg.px;
    assign ty1 = cy1 * st4_c_reg.py;
    assign ty2 = cy2 * st4_c_reg.pz;
    assign tw0 = cw0 * st4_c_reg.px;
    assign tw1 = cw1 * st4_c_reg.py;
    assign tw2 = cw2 * st4_c_reg.pz;

    logic                     st5_v_reg;
    carry_t                   st5_c_reg;
    logic signed [TERM_W-1:0] st5_tx0_reg, st5_tx1_reg, st5_tx2_reg;
    logic signed [TERM_W-1:0] st5_ty0_reg, st5_ty1_reg, st5_ty2_reg;
    logic signed [TERM_W-1:0] st5_tw0_reg, st5_tw1_reg, st5_tw2_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st5_v_reg <= 1'b0;
        end else if (adv) begin
            st5_v_reg <= st4_v_reg;
        end
        if (adv) begin
            st5_c_reg   <= st4_c_reg;
            st5_tx0_reg <= tx0;
            st5_tx1_reg <= tx1;
            st5_tx2_reg <= tx2;
            st5_ty0_reg <= ty0;
            st5_ty1_reg <= ty1;
            st5_ty2_reg <= ty2;
            st5_tw0_reg <= tw0;
            st5_tw1_reg <= tw1;
            st5_tw2_reg <= tw2;
        end
    end

    // Stage 6: partial sums
    logic                    st6_v_reg;
    carry_t                  st6_c_reg;
    logic signed [LIN_W-1:0] st6_ax_reg, st6_bx_reg, st6_ay_reg, st6_by_reg;
    logic signed [LIN_W-1:0] st6_aw_reg, st6_bw_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st6_v_reg <= 1'b0;
        end else if (adv) begin
            st6_v_reg <= st5_v_reg;
        end
        if (adv) begin
            st6_c_reg  <= st5_c_reg;
            st6_ax_reg <= LIN_W'(st5_tx0_reg) + LIN_W'(st5_tx1_reg);
            st6_bx_reg <= LIN_W'(st5_tx2_reg) + LIN_W'(cx3);
            st6_ay_reg <= LIN_W'(st5_ty0_reg) + LIN_W'(st5_ty1_reg);
            st6_by_reg <= LIN_W'(st5_ty2_reg) + LIN_W'(cy3);
            st6_aw_reg <= LIN_W'(st5_tw0_reg) + LIN_W'(st5_tw1_reg);
            st6_bw_reg <= LIN_W'(st5_tw2_reg) + LIN_W'(cw3);
        end
    end

    // Stage 7: full numerators and divisor
    logic                    st7_v_reg;
    carry_t                  st7_c_reg;
    logic signed [LIN_W-1:0] st7_nx_reg, st7_ny_reg, st7_nw_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st7_v_reg <= 1'b0;
        end else if (adv) begin
            st7_v_reg <= st6_v_reg;
        end
        if (adv) begin
            st7_c_reg  <= st6_c_reg;
            st7_nx_reg <= st6_ax_reg + st6_bx_reg;
            st7_ny_reg <= st6_ay_reg + st6_by_reg;
            st7_nw_reg <= st6_aw_reg + st6_bw_reg;
        end
    end

    // Stage 8: magnitudes and quotient signs
    logic              st8_v_reg;
    carry_t            st8_c_reg;
    logic [LIN_W-1:0]  st8_mx_reg, st8_my_reg, st8_mw_reg;
    carry_t            c8_next;

    always_comb begin
        c8_next       = st7_c_reg;
        c8_next.bad   = !map_en_reg || (st7_nw_reg == '0);
        c8_next.neg_x = st7_nx_reg[LIN_W-1] ^ st7_nw_reg[LIN_W-1];
        c8_next.neg_y = st7_ny_reg[LIN_W-1] ^ st7_nw_reg[LIN_W-1];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st8_v_reg <= 1'b0;
        end else if (adv) begin
            st8_v_reg <= st7_v_reg;
        end
        if (adv) begin
            st8_c_reg  <= c8_next;
            st8_mx_reg <= st7_nx_reg[LIN_W-1] ? -st7_nx_reg : st7_nx_reg;
            st8_my_reg <= st7_ny_reg[LIN_W-1] ? -st7_ny_reg : st7_ny_reg;
            st8_mw_reg <= st7_nw_reg[LIN_W-1] ? -st7_nw_reg : st7_nw_reg;
        end
    end

    // Divide both numerators by the divisor
    logic          dv_v;
    logic [QB-1:0] dv_qx, dv_qy;
    carry_t        dv_side;

    dtp_div #(
        .MW (LIN_W),
        .QB (QB)
    ) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (adv),
        .in_valid  (st8_v_reg),
        .in_num_x  (st8_mx_reg),
        .in_num_y  (st8_my_reg),
        .in_den    (st8_mw_reg),
        .in_side   (st8_c_reg),
        .out_valid (dv_v),
        .out_qx    (dv_qx),
        .out_qy    (dv_qy),
        .out_side  (dv_side)
    );

    // Stage A: range check and store address
    logic ok_x, ok_y, hit_next, wok_next;
    assign ok_x = (dv_qx == '0 || !dv_side.neg_x) &&
                  ({1'b0, dv_qx} < (QB+1)'(IMG_WIDTH));
    assign ok_y = (dv_qy == '0 || !dv_side.neg_y) &&
                  ({1'b0, dv_qy} < (QB+1)'(IMG_HEIGHT));
    assign hit_next = dv_side.ld.depth_item && !dv_side.bad && ok_x && ok_y;
    assign wok_next = 32'(dv_side.ld.widx) < 32'(STORE_DEPTH);

    logic          a_v_reg, a_hit_reg, a_wok_reg;
    logic [AW-1:0] a_addr_reg;
    carry_t        a_side_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_v_reg <= 1'b0;
        end else if (adv) begin
            a_v_reg <= dv_v;
        end
        if (adv) begin
            a_side_reg <= dv_side;
            a_hit_reg  <= hit_next;
            a_wok_reg  <= wok_next;
            a_addr_reg <= AW'(dv_qx) + AW'(IMG_WIDTH) * AW'(dv_qy);
        end
    end

    // Stage B: store write for loads, read for depth items
    logic             ram_we;
    logic [RGB_W-1:0] ram_rdata;
    logic             b_hit_reg;

    assign ram_we = adv && a_v_reg && !a_side_reg.ld.depth_item && a_wok_reg;

    dtp_ram #(
        .WIDTH (RGB_W),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (AW'(a_side_reg.ld.widx)),
        .wdata (a_side_reg.ld.wdata),
        .re    (adv),
        .raddr (a_addr_reg),
        .rdata (ram_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_v_reg <= 1'b0;
        end else if (adv) begin
            b_v_reg <= a_v_reg;
        end
        if (adv) begin
            b_side_reg <= a_side_reg;
            b_hit_reg  <= a_hit_reg;
        end
    end

    // Drive the result
    assign m_point_x = b_side_reg.px;
    assign m_point_y = b_side_reg.py;
    assign m_point_z = b_side_reg.pz;
    assign m_out_r   = b_hit_reg ? ram_rdata[3*COLOR_W-1:2*COLOR_W] : '0;
    assign m_out_g   = b_hit_reg ? ram_rdata[2*COLOR_W-1:COLOR_W] : '0;
    assign m_out_b   = b_hit_reg ? ram_rdata[COLOR_W-1:0] : '0;
    assign m_out_a   = b_hit_reg ? ALPHA_FULL : '0;

endmodule

`default_nettype wire

@@ rtl/dtp_checker.sv @@
`default_nettype none

module dtp_checker (
    input logic                             aclk,
    input logic                             aresetn,
    input logic                             s_ready,
    input logic                             m_valid,
    input logic                             m_ready,
    input logic signed [dtp_pkg::PT_W-1:0]  m_point_x,
    input logic signed [dtp_pkg::PT_W-1:0]  m_point_y,
    input logic signed [dtp_pkg::PT_W-1:0]  m_point_z,
    input logic [dtp_pkg::COLOR_W-1:0]      m_out_r,
    input logic [dtp_pkg::COLOR_W-1:0]      m_out_g,
    input logic [dtp_pkg::COLOR_W-1:0]      m_out_b,
    input logic [dtp_pkg::COLOR_W-1:0]      m_out_a
);
    import dtp_pkg::*;

    // No result right after reset
    a_reset_clear: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // Held result keeps its point and alpha
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_point_x) && $stable(m_point_y)
            && $stable(m_point_z) && $stable(m_out_a))
        else $error("held result changed");

    // A held result stalls the input side
    a_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |-> !s_ready)
        else $error("input taken while result held");

    // Alpha is all or nothing
    a_alpha: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_out_a == '0 || m_out_a == ALPHA_FULL))
        else $error("bad alpha");

    // No color without alpha
    a_miss: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_out_a == '0 |-> m_out_r == '0 && m_out_g == '0 && m_out_b == '0)
        else $error("color on unmapped point");

endmodule

bind depth_to_point_rgbd_register dtp_checker u_dtp_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .s_ready   (s_ready),
    .m_valid   (m_valid),
    .m_ready   (m_ready),
    .m_point_x (m_point_x),
    .m_point_y (m_point_y),
    .m_point_z (m_point_z),
    .m_out_r   (m_out_r),
    .m_out_g   (m_out_g),
    .m_out_b   (m_out_b),
    .m_out_a   (m_out_a)
);

`default_nettype wire

@@ test/depth_to_point_rgbd_register_tb.sv @@
`timescale 1ns / 100ps

module depth_to_point_rgbd_register_tb;
    import dtp_pkg::*;

    localparam int STORE_SIZE = IMG_WIDTH_DEF * IMG_HEIGHT_DEF;
    localparam int DRAIN_CYC  = 40;
    localparam int CYC_LIMIT  = 400000;

    typedef struct {
        logic                   req_type;
        logic [IDX_W-1:0]       pixel_index;
        logic [COLOR_W-1:0]     r, g, b;
        logic [DEPTH_W-1:0]     depth;
        logic signed [DIR_W-1:0] dx, dy, dz;
    } pixel_req_t;

    typedef struct {
        logic signed [PT_W-1:0] px, py, pz;
        logic [COLOR_W-1:0]     r, g, b, a;
    } point_res_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_wr_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wr_data = '0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic s_req_type = 1'b0;
    logic [IDX_W-1:0] s_pixel_index = '0;
    logic [COLOR_W-1:0] s_color_r = '0, s_color_g = '0, s_color_b = '0;
    logic [DEPTH_W-1:0] s_depth_mm = '0;
    logic signed [DIR_W-1:0] s_ray_dx = '0, s_ray_dy = '0, s_ray_dz = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic signed [PT_W-1:0] m_point_x, m_point_y, m_point_z;
    logic [COLOR_W-1:0] m_out_r, m_out_g, m_out_b, m_out_a;

    depth_to_point_rgbd_register dut (.*);

    // Shadow configuration
    logic        map_en;
    logic [62:0] origin;
    logic [63:0] cx01, cx23, cy01, cy23, cw01, cw23;

    pixel_req_t  pixel_q[$];
    point_res_t  point_q[$];
    logic [RGB_W-1:0] color_mem[int];
    bit          gen_written[int];
    int          errors = 0;
    bit          calm = 0;
    int          cyc = 0;

    initial begin
        forever #2 aclk = ~aclk;
    end

    function automatic longint sx32(logic [31:0] v);
        return longint'(signed'(v));
    endfunction

    function automatic longint round_coord(longint org, longint dep, longint dir);
        longint s, r;
        s = org * 16384 + dep * dir;
        if (s >= 0) r = (s + 8192) / 16384;
        else r = -((-s + 8192) / 16384);
        if (r > PT_MAX) r = PT_MAX;
        if (r < PT_MIN) r = PT_MIN;
        return r;
    endfunction

    function automatic longint lin_form(logic [63:0] c01, logic [63:0] c23,
                                        longint x, longint y, longint z);
        return sx32(c01[31:0]) * x + sx32(c01[63:32]) * y
             + sx32(c23[31:0]) * z + sx32(c23[63:32]);
    endfunction

    // Back-project one depth item; tgt is the color address read, or -1
    function automatic void back_project(pixel_req_t it, output longint px,
                                         output longint py, output longint pz,
                                         output int tgt);
        longint nx, ny, nw, qx, qy;
        px = round_coord(longint'(signed'(origin[20:0])), it.depth, it.dx);
        py = round_coord(longint'(signed'(origin[41:21])), it.depth, it.dy);
        pz = round_coord(longint'(signed'(origin[62:42])), it.depth, it.dz);
        tgt = -1;
        if (map_en) begin
            nw = lin_form(cw01, cw23, px, py, pz);
            if (nw != 0) begin
                nx = lin_form(cx01, cx23, px, py, pz);
                ny = lin_form(cy01, cy23, px, py, pz);
                qx = nx / nw;
                qy = ny / nw;
                if (qx >= 0 && qx < IMG_WIDTH_DEF && qy >= 0 && qy < IMG_HEIGHT_DEF)
                    tgt = int'(qx + IMG_WIDTH_DEF * qy);
            end
        end
    endfunction

    // Update the color store or queue the expected point
    function automatic void predict_point(pixel_req_t it);
        point_res_t e;
        longint px, py, pz;
        int tgt;
        if (it.req_type == REQ_LOAD) begin
            if (it.pixel_index < STORE_SIZE)
                color_mem[int'(it.pixel_index)] = {it.r, it.g, it.b};
            return;
        end
        back_project(it, px, py, pz, tgt);
        e.px = px[PT_W-1:0];
        e.py = py[PT_W-1:0];
        e.pz = pz[PT_W-1:0];
        {e.r, e.g, e.b, e.a} = '0;
        if (tgt >= 0) begin
            {e.r, e.g, e.b} = color_mem.exists(tgt) ? color_mem[tgt] : '0;
            e.a = ALPHA_FULL;
        end
        point_q.push_back(e);
    endfunction

    function automatic pixel_req_t rand_req();
        pixel_req_t it;
        it.req_type = REQ_LOAD;
        it.pixel_index = IDX_W'($urandom);
        it.r = COLOR_W'($urandom);
        it.g = COLOR_W'($urandom);
        it.b = COLOR_W'($urandom);
        it.depth = DEPTH_W'($urandom);
        it.dx = DIR_W'($urandom);
        it.dy = DIR_W'($urandom);
        it.dz = DIR_W'($urandom);
        return it;
    endfunction

    task automatic add_load(int idx);
        pixel_req_t it;
        it = rand_req();
        it.pixel_index = IDX_W'(idx);
        if (idx < STORE_SIZE) gen_written[idx] = 1;
        pixel_q.push_back(it);
    endtask

    // Queue a depth item, loading its color first where it would be read unwritten
    task automatic add_depth(int dep, int dx, int dy, int dz);
        pixel_req_t it;
        longint px, py, pz;
        int tgt;
        it = rand_req();
        it.req_type = REQ_DEPTH;
        it.depth = DEPTH_W'(dep);
        it.dx = DIR_W'(dx);
        it.dy = DIR_W'(dy);
        it.dz = DIR_W'(dz);
        back_project(it, px, py, pz, tgt);
        if (tgt >= 0 && !gen_written.exists(tgt)) add_load(tgt);
        pixel_q.push_back(it);
    endtask

    task automatic write_cfg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] d);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_wr_index <= idx;
        cfg_wr_data <= d;
        case (idx)
            CFG_MAP_EN: map_en = d[0];
            CFG_ORIGIN: origin = d[62:0];
            CFG_X01:    cx01 = d;
            CFG_X23:    cx23 = d;
            CFG_Y01:    cy01 = d;
            CFG_Y23:    cy23 = d;
            CFG_W01:    cw01 = d;
            CFG_W23:    cw23 = d;
            default: ;
        endcase
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic set_all(logic m, logic [62:0] o, logic [63:0] x01, logic [63:0] x23,
                           logic [63:0] y01, logic [63:0] y23, logic [63:0] w01,
                           logic [63:0] w23);
        write_cfg(CFG_MAP_EN, 64'(m));
        write_cfg(CFG_ORIGIN, 64'(o));
        write_cfg(CFG_X01, x01);
        write_cfg(CFG_X23, x23);
        write_cfg(CFG_Y01, y01);
        write_cfg(CFG_Y23, y23);
        write_cfg(CFG_W01, w01);
        write_cfg(CFG_W23, w23);
    endtask

    // Hold until every queued transfer is done and every result is back
    task automatic drain();
        do @(negedge aclk);
        while (pixel_q.size() != 0 || s_valid || point_q.size() != 0);
        repeat (DRAIN_CYC) @(posedge aclk);
    endtask

    function automatic logic [20:0] rnd21(int lo, int hi);
        return 21'($urandom_range(hi - lo) + lo);
    endfunction

    // Random phase: kind 0 unmapped, 1 near-identity mapping, 2 raw coefficients
    task automatic random_phase(int kind, int n);
        logic [63:0] x01, x23, y01, y23, w01, w23;
        int wc;
        if (kind == 0) begin
            set_all(1'b0, 63'({$urandom, $urandom}), {$urandom, $urandom},
                    {$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                    {$urandom, $urandom}, {$urandom, $urandom});
        end else if (kind == 1) begin
            wc = $urandom_range(1, 3) << 16;
            if ($urandom_range(0, 3) == 0) wc = -wc;
            x01 = {32'd0, 32'(wc / 65536 * $urandom_range(32768, 131072))};
            x23 = {32'(wc / 65536 * ($urandom_range(0, 900) - 200) * 65536), 32'd0};
            y01 = {32'(wc / 65536 * $urandom_range(32768, 131072)), 32'd0};
            y23 = {32'(wc / 65536 * ($urandom_range(0, 700) - 150) * 65536), 32'd0};
            w01 = 64'd0;
            w23 = {32'(wc), 32'($urandom_range(0, 3) == 0 ? $urandom_range(0, 40) : 0)};
            set_all(1'b1, {rnd21(-500, 500), rnd21(-100, 500), rnd21(-100, 600)},
                    x01, x23, y01, y23, w01, w23);
        end else begin
            set_all(1'b1, 63'({$urandom, $urandom}), {$urandom, $urandom},
                    {$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                    {$urandom, $urandom}, {$urandom, $urandom});
        end
        repeat (n) begin
            if ($urandom_range(0, 9) < 3)
                add_load($urandom_range(0, (1 << IDX_W) - 1));
            else if (kind == 1 && $urandom_range(0, 4) != 0)
                add_depth($urandom_range(0, 700), $urandom_range(0, 32767) - 16384,
                          $urandom_range(0, 32767) - 16384, $urandom_range(0, 65535) - 32768);
            else
                add_depth($urandom_range(0, 65535), $urandom_range(0, 65535) - 32768,
                          $urandom_range(0, 65535) - 32768, $urandom_range(0, 65535) - 32768);
        end
        drain();
    endtask

    // Input driver
    pixel_req_t drv_item;
    int         s_gap = 0;
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) predict_point(drv_item);
            if (!s_valid || s_ready) begin
                if (s_gap > 0) begin
                    s_gap <= s_gap - 1;
                    s_valid <= 1'b0;
                end else if (pixel_q.size() != 0) begin
                    drv_item = pixel_q.pop_front();
                    s_req_type <= drv_item.req_type;
                    s_pixel_index <= drv_item.pixel_index;
                    s_color_r <= drv_item.r;
                    s_color_g <= drv_item.g;
                    s_color_b <= drv_item.b;
                    s_depth_mm <= drv_item.depth;
                    s_ray_dx <= drv_item.dx;
                    s_ray_dy <= drv_item.dy;
                    s_ray_dz <= drv_item.dz;
                    s_valid <= 1'b1;
                    if (!calm && $urandom_range(0, 11) == 0) s_gap <= $urandom_range(1, 11);
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    task automatic check_field(string name, longint e, longint a);
        if (e != a) begin
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, e, a);
            errors++;
        end
    endtask

    // Result monitor with random stall bursts
    int m_stall = 0;
    always @(posedge aclk) begin
        point_res_t e;
        cyc <= cyc + 1;
        if (cyc > CYC_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
        if (aresetn && m_valid && m_ready) begin
            if (point_q.size() == 0) begin
                $display("%0t: result with none expected: %0d %0d %0d", $time,
                         m_point_x, m_point_y, m_point_z);
                errors++;
            end else begin
                e = point_q.pop_front();
                check_field("point_x", e.px, m_point_x);
                check_field("point_y", e.py, m_point_y);
                check_field("point_z", e.pz, m_point_z);
                check_field("out_r", e.r, m_out_r);
                check_field("out_g", e.g, m_out_g);
                check_field("out_b", e.b, m_out_b);
                check_field("out_a", e.a, m_out_a);
            end
        end
        if (m_stall > 0) begin
            m_stall <= m_stall - 1;
            m_ready <= 1'b0;
        end else if (aresetn && !calm && $urandom_range(0, 9) == 0) begin
            m_stall <= $urandom_range(0, 10);
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    initial begin
        map_en = 0; origin = '0;
        {cx01, cx23, cy01, cy23, cw01, cw23} = '0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // Unmapped: depth and direction extremes, rounding ties, store edges
        set_all(1'b0, {21'h0FFFFF, 21'h100000, 21'h0}, '1, '1, '1, '1, '1, '1);
        add_load(0);
        add_load(STORE_SIZE - 1);
        add_load(STORE_SIZE);
        add_load((1 << IDX_W) - 1);
        add_depth(0, -32768, 32767, 0);
        add_depth(65535, -32768, 32767, -32768);
        add_depth(65535, 32767, -32768, 32767);
        add_depth(1, 8192, -8192, 8191);
        add_depth(3, -8192, 8192, -8193);
        drain();

        // Identity projection: three corners and one past each edge
        set_all(1'b1, '0, {32'd0, 32'h10000}, '0, {32'h10000, 32'd0}, '0, '0,
                {32'h10000, 32'd0});
        add_depth(0, 0, 0, 0);
        add_depth(639, 16384, 0, 100);
        add_depth(479, 0, 16384, 0);
        add_depth(640, 16384, 0, 0);
        add_depth(480, 16384, 16384, 0);
        add_depth(1, -16384, 0, 0);
        add_depth(1, 0, -16384, 0);
        add_depth(100, 16384 * 2 - 1, 16384 * 2 - 1, 5);
        drain();

        // Zero divisor with mapping on
        write_cfg(CFG_W23, '0);
        add_depth(10, 16384, 16384, 16384);
        add_depth(0, 0, 0, 0);
        drain();

        repeat (3) random_phase(0, 150);
        repeat (5) random_phase(1, 200);
        repeat (2) random_phase(2, 150);
        calm = 1;
        random_phase(1, 250);

        if (errors == 0 && point_q.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
